### src/thr_pkg.sv
// ----------------------------------------------------------------------------
// thr_pkg: shared types and constants of the top-hat r-peak rate block
// widths, window geometry, scaling constants, register indexes, controller
// state encoding and the command/status bundles between control and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thr_pkg;

   // field widths
   localparam int SAMPLE_W   = 10;
   localparam int FEATURE_W  = 14;
   localparam int RATE_W     = 8;
   localparam int SPM_W      = 20;
   localparam int GAP_W      = 16;
   localparam int COUNT_W    = 32;

   // stream and register port widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPM     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MAX = 2'd2;

   // register reset values
   localparam logic [SPM_W-1:0] SPM_RESET     = 20'd15000;
   localparam logic [GAP_W-1:0] GAP_MIN_RESET = 16'd50;
   localparam logic [GAP_W-1:0] GAP_MAX_RESET = 16'd500;

   // window geometry
   localparam int WINDOW_LEN  = 64;
   localparam int WIN_AW      = $clog2(WINDOW_LEN);
   localparam int LEAD_DELAY  = 8;
   localparam int LAG_DELAY   = 8;
   localparam int DELTA_DEPTH = LEAD_DELAY + LAG_DELAY + 1;
   localparam int WARM_COUNT  = WINDOW_LEN + LAG_DELAY;

   localparam logic [SAMPLE_W-1:0] EROSION_CAP = 10'd300;
   localparam logic [FEATURE_W-1:0] PEAK_LEVEL = 14'd10;

   // product and scaling: p / 1024 / 9 * 90
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int PROD_SHIFT = 10;
   localparam int SCL_X_W    = 10;
   localparam int DIV9_MULT  = 7282;  // ceil(2^16 / 9), exact for x below 1024
   localparam int DIV9_SHIFT = 16;
   localparam int SCL_W      = 23;
   localparam int Q_W        = 7;
   localparam logic [FEATURE_W-1:0] FEAT_GAIN = 14'd90;

   localparam logic [RATE_W-1:0] RATE_SAT = 8'd255;

   // rate divider
   localparam int DIV_STEPS = SPM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DELTA,
      ST_MUL,
      ST_SCALE,
      ST_DECIDE,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;      // capture sample, write it into the ring
      logic scan;      // issue one ring read for the erosion
      logic delta;     // shift the top-hat delta into the delay line
      logic mul;       // register the window product
      logic scale;     // register the scaled quotient
      logic decide;    // peak decision, state update, divider start
      logic out_load;  // move the result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic warm;
      logic div_req;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### src/tophat_ecg_rpeak_rate_top.sv
// ----------------------------------------------------------------------------
// tophat_ecg_rpeak_rate_top: top-hat qrs detector and heart-rate meter
// throughput: one sample at a time, the next is taken only once the last is through;
//   the pace is set by the 64-entry erosion scan over the single read port of the
//   sample ring plus, on a rate update, the restoring divider (20 quotient steps and
//   its done flag), and by any stall of the result channel
// reset: synchronous, active high; the ring memory is not cleared, a fill flag
//   stands in for its zeros, so samples are taken from the first cycle after
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tophat_ecg_rpeak_rate_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample input channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [thr_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [9:0] sample, [15:10] zero
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [thr_pkg::RSP_TDATA_W-1:0]          rsp_tdata,   // [13:0] feature,
                                                                 // [21:14] heart_rate,
                                                                 // [23:22] zero
   output logic                                     rsp_tuser,   // [0] peak_found
   // register write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [thr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [thr_pkg::CSR_DATA_W-1:0]      csr_data
);

   thr_pkg::ctrl_cmd_type  cmd;
   thr_pkg::dp_status_type status;

   // registers taken on any cycle; the user must write only while idle, not enforced
   assign csr_ready = 1'b1;

   // sequencer: the input side is open only in the idle state; a result that
   // still waits in the output register does not hold off the next sample,
   // only the next result
   thr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: ring write on the accept beat, then one ring read per cycle for
   // the running minimum, delta shift, window product, scaling, decision and
   // optional rate division; the first 72 samples give no result
   thr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   // an accepted beat always starts the erosion scan next
   a_accept_then_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.scan)
      else $error("scan did not follow an accepted sample");

   // the result register is never overwritten while a result is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register loaded while occupied");

   // a marked peak always carries a feature at or above the peak level
   a_peak_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[thr_pkg::FEATURE_W-1:0] >= thr_pkg::PEAK_LEVEL))
      else $error("peak marked with a low feature");
`endif

endmodule

`default_nettype wire

### src/thr_divider.sv
// ----------------------------------------------------------------------------
// thr_divider: restoring divider for the heart rate
// one quotient bit per cycle, samples per minute over the peak gap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thr_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [thr_pkg::SPM_W-1:0]   dividend,
   input  wire logic [thr_pkg::GAP_W-1:0]   divisor,
   output logic                             done,
   output logic [thr_pkg::SPM_W-1:0]        quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [thr_pkg::GAP_W-1:0]         rem_ff, rem_in;
   logic [thr_pkg::SPM_W-1:0]         quo_ff, quo_in;
   logic [thr_pkg::GAP_W-1:0]         dvs_ff, dvs_in;
   logic [thr_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [thr_pkg::GAP_W:0]           shifted;
   logic [thr_pkg::GAP_W:0]           diff;
   logic                              fits;

   assign shifted = {rem_ff, quo_ff[thr_pkg::SPM_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[thr_pkg::GAP_W-1:0] : shifted[thr_pkg::GAP_W-1:0];
         quo_in = {quo_ff[thr_pkg::SPM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == thr_pkg::DIV_CNT_W'(thr_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### src/thr_datapath.sv
// ----------------------------------------------------------------------------
// thr_datapath: sample ring, erosion scan, delta line, feature and peak state
// holds the configuration registers and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thr_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire thr_pkg::ctrl_cmd_type               cmd,
   output thr_pkg::dp_status_type                   status,
   input  wire logic [thr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                csr_valid,
   input  wire logic [thr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [thr_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [thr_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tuser
);

   // configuration
   logic [thr_pkg::SPM_W-1:0]      spm_ff;
   logic [thr_pkg::GAP_W-1:0]      gap_min_ff;
   logic [thr_pkg::GAP_W-1:0]      gap_max_ff;

   // sample ring and erosion scan
   logic [thr_pkg::SAMPLE_W-1:0]   ring_mem [thr_pkg::WINDOW_LEN];
   logic [thr_pkg::WIN_AW-1:0]     wp_ff;
   logic [thr_pkg::WIN_AW-1:0]     scan_idx_ff;
   logic [thr_pkg::SAMPLE_W-1:0]   rd_ff;
   logic                           rd_valid_ff;
   logic [thr_pkg::SAMPLE_W-1:0]   sample_ff;
   logic [thr_pkg::SAMPLE_W-1:0]   min_ff;

   // delta line, product, scale
   logic [thr_pkg::SAMPLE_W-1:0]   delta_ff [thr_pkg::DELTA_DEPTH];
   logic signed [thr_pkg::PROD_W-1:0] prod_ff;
   logic [thr_pkg::Q_W-1:0]        q_ff;

   // detector state
   logic [thr_pkg::COUNT_W-1:0]    count_ff;
   logic [thr_pkg::COUNT_W-1:0]    last_peak_ff;
   logic                           armed_ff;
   logic                           warm_ff;
   logic                           full_ff;
   logic [thr_pkg::RATE_W-1:0]     rate_ff;
   logic                           peak_ff;
   logic [thr_pkg::FEATURE_W-1:0]  feature_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [thr_pkg::FEATURE_W-1:0]  rsp_feature_ff;
   logic                           rsp_peak_ff;
   logic [thr_pkg::RATE_W-1:0]     rsp_rate_ff;

   // combinational
   logic                           warm;
   logic                           full;
   logic [thr_pkg::SAMPLE_W-1:0]   erosion;
   logic [thr_pkg::SAMPLE_W-1:0]   delta;
   logic signed [thr_pkg::DIFF_W-1:0] diff_lead;
   logic signed [thr_pkg::DIFF_W-1:0] diff_new;
   logic                           prod_pos;
   logic [thr_pkg::SCL_X_W-1:0]    scl_x;
   logic [thr_pkg::SCL_W-1:0]      scaled;
   logic [thr_pkg::FEATURE_W-1:0]  feature;
   logic                           is_low;
   logic [thr_pkg::COUNT_W-1:0]    centre;
   logic [thr_pkg::COUNT_W-1:0]    gap;
   logic                           gap_ok;
   logic                           new_peak;
   logic                           div_start;
   logic                           div_done;
   logic [thr_pkg::SPM_W-1:0]      div_quo;

   // configuration writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff     <= thr_pkg::SPM_RESET;
         gap_min_ff <= thr_pkg::GAP_MIN_RESET;
         gap_max_ff <= thr_pkg::GAP_MAX_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            thr_pkg::CSR_SPM:     spm_ff     <= csr_data;
            thr_pkg::CSR_GAP_MIN: gap_min_ff <= csr_data[thr_pkg::GAP_W-1:0];
            thr_pkg::CSR_GAP_MAX: gap_max_ff <= csr_data[thr_pkg::GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // ring memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ring_mem[wp_ff] <= req_tdata[thr_pkg::SAMPLE_W-1:0];
      end
      rd_ff <= ring_mem[scan_idx_ff];
   end

   // erosion scan
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         rd_valid_ff <= cmd.scan;
         if (cmd.load) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan) begin
            scan_idx_ff <= (scan_idx_ff == thr_pkg::WIN_AW'(thr_pkg::WINDOW_LEN - 1)) ?
                           '0 : scan_idx_ff + 1'b1;
         end
      end
      if (cmd.load) begin
         sample_ff <= req_tdata[thr_pkg::SAMPLE_W-1:0];
         min_ff    <= thr_pkg::EROSION_CAP;
      end else if (rd_valid_ff && (rd_ff < min_ff)) begin
         min_ff <= rd_ff;
      end
   end

   // ring entries are not cleared; until the ring is full the erosion counts as zero
   assign full    = full_ff || (count_ff >= thr_pkg::COUNT_W'(thr_pkg::WINDOW_LEN - 1));
   assign warm    = warm_ff || (count_ff >= thr_pkg::COUNT_W'(thr_pkg::WARM_COUNT));
   assign erosion = full ? min_ff : '0;
   assign delta   = sample_ff - erosion;

   // taps: newest at 0, centre at lag, lead sample further back
   assign diff_lead = $signed({1'b0, delta_ff[thr_pkg::LAG_DELAY]}) -
                      $signed({1'b0, delta_ff[thr_pkg::LAG_DELAY + thr_pkg::LEAD_DELAY]});
   assign diff_new  = $signed({1'b0, delta_ff[thr_pkg::LAG_DELAY]}) -
                      $signed({1'b0, delta_ff[0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < thr_pkg::DELTA_DEPTH; i++) begin
            delta_ff[i] <= '0;
         end
      end else if (cmd.delta) begin
         delta_ff[0] <= delta;
         for (int i = 1; i < thr_pkg::DELTA_DEPTH; i++) begin
            delta_ff[i] <= delta_ff[i-1];
         end
      end
   end

   // product and scaling
   assign prod_pos = !prod_ff[thr_pkg::PROD_W-1] && (prod_ff != '0);
   assign scl_x    = prod_ff[thr_pkg::PROD_SHIFT +: thr_pkg::SCL_X_W];
   assign scaled   = thr_pkg::SCL_W'(scl_x) * thr_pkg::SCL_W'(thr_pkg::DIV9_MULT);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= diff_lead * diff_new;
      end
      if (cmd.scale) begin
         q_ff <= prod_pos ? scaled[thr_pkg::DIV9_SHIFT +: thr_pkg::Q_W] : '0;
      end
   end

   // peak decision
   assign feature  = thr_pkg::FEATURE_W'(q_ff) * thr_pkg::FEAT_GAIN;
   assign is_low   = feature < thr_pkg::PEAK_LEVEL;
   assign centre   = count_ff - thr_pkg::COUNT_W'(thr_pkg::LAG_DELAY);
   assign gap      = centre - last_peak_ff;
   assign gap_ok   = (gap < thr_pkg::COUNT_W'(gap_max_ff)) &&
                     (gap > thr_pkg::COUNT_W'(gap_min_ff));
   assign new_peak = warm && !is_low && armed_ff;
   assign div_start = cmd.decide && new_peak && gap_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_peak_ff <= '0;
         armed_ff     <= 1'b0;
         warm_ff      <= 1'b0;
         full_ff      <= 1'b0;
         rate_ff      <= '0;
         wp_ff        <= '0;
      end else begin
         if (cmd.decide) begin
            count_ff <= count_ff + 1'b1;
            warm_ff  <= warm;
            full_ff  <= full;
            wp_ff    <= (wp_ff == thr_pkg::WIN_AW'(thr_pkg::WINDOW_LEN - 1)) ?
                        '0 : wp_ff + 1'b1;
            if (warm) begin
               armed_ff <= is_low;
            end
            if (new_peak) begin
               last_peak_ff <= centre;
            end
         end
         if (div_done) begin
            rate_ff <= (div_quo > thr_pkg::SPM_W'(thr_pkg::RATE_SAT)) ?
                       thr_pkg::RATE_SAT : div_quo[thr_pkg::RATE_W-1:0];
         end
      end
      if (cmd.decide) begin
         feature_ff <= feature;
         peak_ff    <= new_peak;
      end
   end

   thr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (spm_ff),
      .divisor  (gap[thr_pkg::GAP_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_feature_ff <= feature_ff;
         rsp_peak_ff    <= peak_ff;
         rsp_rate_ff    <= rate_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(thr_pkg::RSP_TDATA_W - thr_pkg::FEATURE_W - thr_pkg::RATE_W){1'b0}},
                        rsp_rate_ff, rsp_feature_ff};
   assign rsp_tuser  = rsp_peak_ff;

   assign status.scan_last = scan_idx_ff == thr_pkg::WIN_AW'(thr_pkg::WINDOW_LEN - 1);
   assign status.warm      = warm;
   assign status.div_req   = new_peak && gap_ok;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

### src/thr_ctrl.sv
// ----------------------------------------------------------------------------
// thr_ctrl: sequencer of one sample through scan, feature, decision and divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire thr_pkg::dp_status_type  status,
   output thr_pkg::ctrl_cmd_type        cmd
);

   thr_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= thr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         thr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = thr_pkg::ST_SCAN;
            end
         end
         thr_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = thr_pkg::ST_DRAIN;
            end
         end
         thr_pkg::ST_DRAIN: begin
            state_in = thr_pkg::ST_DELTA;
         end
         thr_pkg::ST_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = thr_pkg::ST_MUL;
         end
         thr_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = thr_pkg::ST_SCALE;
         end
         thr_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = thr_pkg::ST_DECIDE;
         end
         thr_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (!status.warm) begin
               state_in = thr_pkg::ST_IDLE;
            end else if (status.div_req) begin
               state_in = thr_pkg::ST_DIV;
            end else begin
               state_in = thr_pkg::ST_OUT;
            end
         end
         thr_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = thr_pkg::ST_OUT;
            end
         end
         thr_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = thr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = thr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the top-hat r-peak rate block
// streams ecg-like sample beats with randomized gaps and back-pressure,
// predicts every feature/peak/rate beat with an in-bench model of the erosion,
// top-hat delta line and peak/rate logic, and walks several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int RX_HOLD_CYCLES = 700;
   localparam int MAX_GAP        = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 50;
   localparam int NUM_PHASES     = 7;
   localparam int NUM_ROWS       = 14;
   localparam int SAMPLE_MAX     = 1023;

   // index past the three registers, must be ignored
   localparam logic [thr_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one result beat as the block reports it
   typedef struct packed {
      logic [thr_pkg::FEATURE_W-1:0] feature;
      logic                          peak_found;
      logic [thr_pkg::RATE_W-1:0]    heart_rate;
   } rpeak_result_type;

   // directed stimulus row: a sample repeated reps times, optionally with a
   // hand-typed result for the last repeat
   typedef struct {
      logic [thr_pkg::SAMPLE_W-1:0] sample;
      int                           reps;
      bit                           typed;
      rpeak_result_type             result;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [thr_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [thr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [thr_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [thr_pkg::CSR_DATA_W-1:0]  csr_data;

   tophat_ecg_rpeak_rate_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // ------------------------------------------------------------------------
   // detector model state: sample window, delta delay line, peak tracking
   // ------------------------------------------------------------------------
   logic [thr_pkg::SAMPLE_W-1:0] mdl_window [thr_pkg::WINDOW_LEN];
   logic [thr_pkg::SAMPLE_W-1:0] mdl_delta  [thr_pkg::DELTA_DEPTH];
   int                           mdl_wr_win;
   int                           mdl_wr_delta;
   logic [thr_pkg::COUNT_W-1:0]  mdl_count;
   logic [thr_pkg::COUNT_W-1:0]  mdl_last_peak;
   bit                           mdl_armed;
   bit                           mdl_warm;
   logic [thr_pkg::RATE_W-1:0]   mdl_rate;
   logic [thr_pkg::SPM_W-1:0]    mdl_spm;
   logic [thr_pkg::GAP_W-1:0]    mdl_gap_min;
   logic [thr_pkg::GAP_W-1:0]    mdl_gap_max;

   rpeak_result_type pending_rpeak_q [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               tx_burst = 1'b0;
   bit               rx_burst = 1'b0;
   bit               rx_hold_req = 1'b0;

   // push the expected beat (if any) caused by one accepted sample
   task automatic predict_rpeak(input logic [thr_pkg::SAMPLE_W-1:0] s);
      logic [thr_pkg::SAMPLE_W-1:0] floor_val;
      int                           centre_i;
      int                           lead_i;
      int                           dc;
      int                           prod;
      logic [thr_pkg::COUNT_W-1:0]  centre;
      logic [thr_pkg::COUNT_W-1:0]  gap;
      logic [thr_pkg::COUNT_W-1:0]  quot;
      rpeak_result_type             res;
      mdl_window[mdl_wr_win] = s;
      // erosion: window minimum, never above the cap
      floor_val = thr_pkg::EROSION_CAP;
      foreach (mdl_window[i])
         if (mdl_window[i] < floor_val) floor_val = mdl_window[i];
      mdl_delta[mdl_wr_delta] = s - floor_val;
      if (!mdl_warm && mdl_count >= thr_pkg::WARM_COUNT) mdl_warm = 1'b1;
      if (mdl_warm) begin
         centre_i = (mdl_wr_delta + thr_pkg::DELTA_DEPTH - thr_pkg::LAG_DELAY) %
                    thr_pkg::DELTA_DEPTH;
         lead_i   = (centre_i + thr_pkg::DELTA_DEPTH - thr_pkg::LEAD_DELAY) %
                    thr_pkg::DELTA_DEPTH;
         dc       = int'(mdl_delta[centre_i]);
         prod     = (dc - int'(mdl_delta[lead_i])) * (dc - int'(mdl_delta[mdl_wr_delta]));
         res.feature    = (prod > 0) ? thr_pkg::FEATURE_W'(prod / 1024 / 9 * 90) : '0;
         res.peak_found = 1'b0;
         if (res.feature < thr_pkg::PEAK_LEVEL) begin
            mdl_armed = 1'b1;
         end else begin
            if (mdl_armed) begin
               centre = mdl_count - thr_pkg::COUNT_W'(thr_pkg::LAG_DELAY);
               gap    = centre - mdl_last_peak;
               if (gap < mdl_gap_max && gap > mdl_gap_min) begin
                  quot     = mdl_spm / gap;
                  mdl_rate = (quot > thr_pkg::RATE_SAT) ?
                             thr_pkg::RATE_SAT : quot[thr_pkg::RATE_W-1:0];
               end
               mdl_last_peak  = centre;
               res.peak_found = 1'b1;
            end
            mdl_armed = 1'b0;
         end
         res.heart_rate = mdl_rate;
         pending_rpeak_q.push_back(res);
      end
      mdl_wr_win   = (mdl_wr_win + 1) % thr_pkg::WINDOW_LEN;
      mdl_wr_delta = (mdl_wr_delta + 1) % thr_pkg::DELTA_DEPTH;
      mdl_count    = mdl_count + 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // drivers: everything changes on the falling edge, handshakes are sampled
   // on the rising edge
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [thr_pkg::SAMPLE_W-1:0] s, input bit typed,
                              input rpeak_result_type typed_res);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= thr_pkg::REQ_TDATA_W'(s);
      do @(posedge clock); while (!req_tready);
      predict_rpeak(s);
      // hand-typed rows override the model's beat for this sample
      if (typed) pending_rpeak_q[pending_rpeak_q.size() - 1] = typed_res;
   endtask

   task automatic send_plain(input int s);
      send_sample(thr_pkg::SAMPLE_W'(s), 1'b0, '0);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rpeak_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [thr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [thr_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         thr_pkg::CSR_SPM:     mdl_spm     = value[thr_pkg::SPM_W-1:0];
         thr_pkg::CSR_GAP_MIN: mdl_gap_min = value[thr_pkg::GAP_W-1:0];
         thr_pkg::CSR_GAP_MAX: mdl_gap_max = value[thr_pkg::GAP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // gap registers take the low bits only; junk above them must not matter
   function automatic logic [thr_pkg::CSR_DATA_W-1:0] gap_word(
      input logic [thr_pkg::GAP_W-1:0] g);
      return thr_pkg::CSR_DATA_W'(g) |
             (thr_pkg::CSR_DATA_W'($urandom_range(0, 15)) << thr_pkg::GAP_W);
   endfunction

   function automatic int clamp_sample(input int v);
      return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
   endfunction

   // ------------------------------------------------------------------------
   // result checking against the oldest pending beat
   // ------------------------------------------------------------------------
   task automatic check_rpeak(input rpeak_result_type got);
      rpeak_result_type want;
      if (pending_rpeak_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected beat: feature %0d peak %0d rate %0d",
                     got.feature, got.peak_found, got.heart_rate);
      end else begin
         want = pending_rpeak_q.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch (exp/got): feature %0d/%0d peak %0d/%0d rate %0d/%0d",
                        want.feature, got.feature, want.peak_found, got.peak_found,
                        want.heart_rate, got.heart_rate);
         end
      end
   endtask

   // result sink: random stalls, bursts of full readiness, and one long
   // hold-off on request so the block backs up into its input
   initial begin : result_sink
      int               stall;
      int               taken;
      rpeak_result_type got;
      taken = 0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
         if (rx_hold_req) begin
            stall = RX_HOLD_CYCLES;
            rx_hold_req = 1'b0;
         end else begin
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.feature    = rsp_tdata[thr_pkg::FEATURE_W-1:0];
         got.heart_rate = rsp_tdata[thr_pkg::FEATURE_W +: thr_pkg::RATE_W];
         got.peak_found = rsp_tuser;
         check_rpeak(got);
         taken++;
      end
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[tophat_ecg_rpeak_rate_top] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus: directed rows at reset settings, then register phases of
   // ecg-like random traffic
   // ------------------------------------------------------------------------
   stim_row_type                directed_rows [NUM_ROWS];
   logic [thr_pkg::SPM_W-1:0]   cfg_spm  [NUM_PHASES];
   logic [thr_pkg::GAP_W-1:0]   cfg_gmin [NUM_PHASES];
   logic [thr_pkg::GAP_W-1:0]   cfg_gmax [NUM_PHASES];

   initial begin : stimulus
      int  phase;
      int  k;
      int  r;
      int  width;
      int  level;
      int  lo;
      int  base;
      int  beat_in;
      bit  paused;
      bit  hold_issued;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = thr_pkg::CSR_SPM;
      csr_data   = '0;

      foreach (mdl_window[i]) mdl_window[i] = '0;
      foreach (mdl_delta[i]) mdl_delta[i] = '0;
      mdl_wr_win    = 0;
      mdl_wr_delta  = 0;
      mdl_count     = '0;
      mdl_last_peak = '0;
      mdl_armed     = 1'b0;
      mdl_warm      = 1'b0;
      mdl_rate      = '0;
      mdl_spm       = thr_pkg::SPM_RESET;
      mdl_gap_min   = thr_pkg::GAP_MIN_RESET;
      mdl_gap_max   = thr_pkg::GAP_MAX_RESET;

      // warm-up: zeros until the first beat comes out
      directed_rows[0]  = '{10'd0,    72, 1'b0, '{14'd0, 1'b0, 8'd0}};
      // first beat after warm-up is all zero
      directed_rows[1]  = '{10'd0,     1, 1'b1, '{14'd0, 1'b0, 8'd0}};
      // full-scale sample as newest: centre still flat, product zero
      directed_rows[2]  = '{10'd1023,  1, 1'b1, '{14'd0, 1'b0, 8'd0}};
      directed_rows[3]  = '{10'd0,     7, 1'b0, '{14'd0, 1'b0, 8'd0}};
      // full-scale spike reaches the centre: largest feature, first peak,
      // gap 73 gives 15000 / 73
      directed_rows[4]  = '{10'd0,     1, 1'b1, '{14'd10170, 1'b1, 8'd205}};
      directed_rows[5]  = '{10'd0,    20, 1'b0, '{14'd0, 1'b0, 8'd0}};
      directed_rows[6]  = '{10'h2aa,   4, 1'b0, '{14'd0, 1'b0, 8'd0}};
      directed_rows[7]  = '{10'h155,   4, 1'b0, '{14'd0, 1'b0, 8'd0}};
      directed_rows[8]  = '{10'd1023,  2, 1'b0, '{14'd0, 1'b0, 8'd0}};
      directed_rows[9]  = '{10'd0,    10, 1'b0, '{14'd0, 1'b0, 8'd0}};
      // spike too soon after the last peak: marked, rate left alone
      directed_rows[10] = '{10'd1023,  1, 1'b0, '{14'd0, 1'b0, 8'd0}};
      directed_rows[11] = '{10'd0,    12, 1'b0, '{14'd0, 1'b0, 8'd0}};
      // plateau above the erosion cap
      directed_rows[12] = '{10'd512,  16, 1'b0, '{14'd0, 1'b0, 8'd0}};
      directed_rows[13] = '{10'd0,     9, 1'b0, '{14'd0, 1'b0, 8'd0}};

      // phase settings: saturating rate with the widest gap window, zero
      // numerator, empty window, smallest non-zero numerator, random, one-wide window
      // that still admits nothing, fully random
      cfg_spm[0] = 20'd1000000; cfg_gmin[0] = 16'd0;     cfg_gmax[0] = 16'hffff;
      cfg_spm[1] = 20'd0;       cfg_gmin[1] = 16'd30;    cfg_gmax[1] = 16'd400;
      cfg_spm[2] = 20'hfffff;   cfg_gmin[2] = 16'hffff;  cfg_gmax[2] = 16'd0;
      cfg_spm[3] = 20'd1;       cfg_gmin[3] = 16'd20;    cfg_gmax[3] = 16'd300;
      cfg_spm[4] = thr_pkg::SPM_W'($urandom_range(1000, 40000));
      cfg_gmin[4] = thr_pkg::GAP_W'($urandom_range(20, 60));
      cfg_gmax[4] = thr_pkg::GAP_W'($urandom_range(100, 400));
      cfg_spm[5] = 20'd12000;   cfg_gmin[5] = 16'd100;   cfg_gmax[5] = 16'd101;
      cfg_spm[6] = thr_pkg::SPM_W'($urandom_range(0, 20'hfffff));
      cfg_gmin[6] = thr_pkg::GAP_W'($urandom_range(0, 80));
      cfg_gmax[6] = thr_pkg::GAP_W'($urandom_range(60, 65535));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[row]) begin
         for (int n = 0; n < directed_rows[row].reps; n++)
            send_sample(directed_rows[row].sample,
                        directed_rows[row].typed && (n == directed_rows[row].reps - 1),
                        directed_rows[row].result);
      end

      base        = 200;
      beat_in     = 20;
      hold_issued = 1'b0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // registers only change with the block idle
         stop_sending();
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_csr(thr_pkg::CSR_SPM, thr_pkg::CSR_DATA_W'(cfg_spm[phase]));
         write_csr(thr_pkg::CSR_GAP_MIN, gap_word(cfg_gmin[phase]));
         write_csr(thr_pkg::CSR_GAP_MAX, gap_word(cfg_gmax[phase]));
         if (phase == 2)
            write_csr(CSR_UNUSED, thr_pkg::CSR_DATA_W'($urandom_range(0, 20'hfffff)));

         k      = 0;
         paused = 1'b0;
         while (k < PHASE_ITEMS) begin
            if ($urandom_range(0, 30) == 0) tx_burst = !tx_burst;
            // long sink hold-off while this side keeps pushing
            if (phase == 1 && !hold_issued && k >= 5) begin
               rx_hold_req = 1'b1;
               hold_issued = 1'b1;
            end
            // mid-phase pause until every pending beat has come back
            if (!paused && k >= PHASE_ITEMS / 2) begin
               stop_sending();
               wait_drained();
               paused = 1'b1;
            end
            if (beat_in == 0) begin
               // qrs complex: mostly a narrow spike, sometimes a dip or a
               // wide plateau that should not look like a clean beat
               r     = $urandom_range(0, 9);
               width = (r == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
               lo    = clamp_sample(base + 150);
               level = (r == 1) ? 0 : $urandom_range(lo, SAMPLE_MAX);
               for (int w = 0; w < width; w++)
                  send_plain(clamp_sample(level + $urandom_range(0, 30) - 15));
               k       = k + width;
               beat_in = $urandom_range(35, 160);
            end else begin
               r = $urandom_range(0, 99);
               if (r < 6) begin
                  send_plain($urandom_range(0, SAMPLE_MAX));
               end else if (r < 8) begin
                  // baseline wander, often above the erosion cap
                  base = $urandom_range(0, 900);
                  send_plain(base);
               end else begin
                  send_plain(clamp_sample(base + $urandom_range(0, 16) - 8));
               end
               k++;
               beat_in--;
            end
         end
      end

      stop_sending();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rpeak_q.size() == 0)
         $display("[tophat_ecg_rpeak_rate_top] OK");
      else
         $display("[tophat_ecg_rpeak_rate_top] ERROR");
      $finish;
   end

endmodule

### sim.f
src/thr_pkg.sv
src/thr_divider.sv
src/thr_datapath.sv
src/thr_ctrl.sv
src/tophat_ecg_rpeak_rate_top.sv
tb/sv/tb_top.sv
